FILE: rtl/core/u2d_pkg.sv
package u2d_pkg;

    localparam int VALUE_W  = 32;
    localparam int NUM_DIG  = 10;
    localparam int NIB_W    = 4;
    localparam int CNT_W    = 4;
    localparam int CHAR_W   = 6;
    localparam int BIT_CNTW = $clog2(VALUE_W);

    // ASCII '0' is 6'b110000, so a digit 0..9 maps to {2'b11, digit}
    localparam logic [1:0] ASCII_ZERO_HI = 2'b11;

    typedef logic [NUM_DIG-1:0][NIB_W-1:0] t_bcd;

    typedef struct packed {
        t_bcd             bcd;
        logic [CNT_W-1:0] count;
    } t_entry;

endpackage

FILE: rtl/core/u2d_front.sv
module u2d_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [u2d_pkg::VALUE_W-1:0]    i_value,
    output logic                           o_full,
    output logic                           o_q_push,
    output u2d_pkg::t_entry                o_q_data,
    input  logic                           i_q_full
);
    import u2d_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SHIFT = 3'b010,
        S_PUSH  = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [BIT_CNTW-1:0]         r_bit, n_bit;
    logic [VALUE_W-1:0]          r_bin, n_bin;
    t_bcd                        r_bcd, n_bcd;
    t_bcd                        adj;
    logic [NUM_DIG*NIB_W-1:0]    adj_flat;
    logic [CNT_W-1:0]            digit_count;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIG; i++) begin
            adj[i] = (r_bcd[i] >= NIB_W'(5)) ? r_bcd[i] + NIB_W'(3) : r_bcd[i];
        end
    end

    assign adj_flat = adj;

    // position of the highest nonzero digit; zero still has one digit
    always_comb begin
        digit_count = CNT_W'(1);
        for (int i = 0; i < NUM_DIG; i++) begin
            if (r_bcd[i] != '0) begin
                digit_count = CNT_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        unique case (r_state)
            S_IDLE: begin
                if (i_push) begin
                    n_state = S_SHIFT;
                    n_bit   = BIT_CNTW'(VALUE_W - 1);
                    n_bin   = i_value;
                    n_bcd   = '0;
                end
            end
            S_SHIFT: begin
                n_bcd = {adj_flat[NUM_DIG*NIB_W-2:0], r_bin[VALUE_W-1]};
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                n_bit = r_bit - BIT_CNTW'(1);
                if (r_bit == '0) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_q_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_full         = (r_state != S_IDLE);
    assign o_q_push       = (r_state == S_PUSH) && !i_q_full;
    assign o_q_data.bcd   = r_bcd;
    assign o_q_data.count = digit_count;

endmodule

FILE: rtl/core/u2d_fifo.sv
module u2d_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u2d_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output u2d_pkg::t_entry o_data,
    output logic            o_empty
);
    import u2d_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/u2d_back.sv
module u2d_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  u2d_pkg::t_entry               i_q_data,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [u2d_pkg::CHAR_W-1:0]    o_digit_char,
    output logic [u2d_pkg::CNT_W-1:0]     o_digit_count,
    output logic                          o_last
);
    import u2d_pkg::*;

    logic             r_valid;
    t_bcd             r_bcd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_pos;
    logic             at_last, take, load;

    assign at_last = (r_pos == '0);
    assign take    = r_valid && i_pop;
    // refill when idle or when the final digit of a run leaves
    assign load    = !i_q_empty && (!r_valid || (take && at_last));
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (take && at_last) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bcd   <= i_q_data.bcd;
            r_count <= i_q_data.count;
            r_pos   <= i_q_data.count - CNT_W'(1);
        end else if (take) begin
            r_pos   <= r_pos - CNT_W'(1);
        end
    end

    assign o_empty       = !r_valid;
    assign o_digit_char  = {ASCII_ZERO_HI, r_bcd[r_pos]};
    assign o_digit_count = r_count;
    assign o_last        = at_last;

endmodule

FILE: rtl/core/unsigned_to_decimal_digits_unit.sv
// Path: an accepted value passes 32 shift-add-3 steps in the front converter,
//   is enqueued, then is loaded into the emitter that gives its first digit.
// Throughput: a new value is taken only once the 32-step converter has enqueued
//   the last one; digits of a run leave one per cycle while pop is held.
// Reset: synchronous active-low reset empties the queue and idles both sides.
module unsigned_to_decimal_digits_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [u2d_pkg::VALUE_W-1:0]   i_value,
    output logic                          empty,
    input  logic                          pop,
    output logic [u2d_pkg::CHAR_W-1:0]    o_digit_char,
    output logic [u2d_pkg::CNT_W-1:0]     o_digit_count,
    output logic                          o_last
);
    import u2d_pkg::*;

    logic   q_push, q_full, q_pop, q_empty;
    t_entry q_wdata, q_rdata;

    u2d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_value  (i_value),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    u2d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    u2d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_data      (q_rdata),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_digit_char  (o_digit_char),
        .o_digit_count (o_digit_count),
        .o_last        (o_last)
    );

endmodule

FILE: tb/sv/tb_unsigned_to_decimal_digits_unit.sv
module tb_unsigned_to_decimal_digits_unit;

    import u2d_pkg::*;

    localparam int unsigned ASCII_ZERO_CODE = 48;
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned TAIL_CYCLES     = 40;
    localparam int unsigned REPORT_MAX      = 10;
    localparam int unsigned RANDOM_PER_PHASE = 90;
    localparam int unsigned NUM_PHASES      = 4;

    localparam logic [VALUE_W-1:0] CORNER_VALUES [21] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
        32'd99999, 32'd100000, 32'd9999999, 32'd10000000,
        32'd999999999, 32'd1000000000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'hAAAA_AAAA, 32'h5555_5555, 32'd4000000000, 32'hFFFF_FFFE,
        32'hFFFF_FFFF
    };

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic [CNT_W-1:0]  digit_count;
        logic              last;
    } t_digit;

    class digit_scoreboard;
        t_digit      expected_q[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // Expand a value into its decimal digits, most significant first.
        function void note_value(logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] rest;
            int unsigned        lsd_first[$];
            int unsigned        ndig;
            t_digit             d;
            rest = value;
            do begin
                lsd_first.push_back(rest % 10);
                rest = rest / 10;
            end while (rest != 0);
            ndig = lsd_first.size();
            for (int i = 0; i < ndig; i++) begin
                d.digit_char  = CHAR_W'(ASCII_ZERO_CODE + lsd_first[ndig-1-i]);
                d.digit_count = CNT_W'(ndig);
                d.last        = (i == ndig - 1);
                expected_q.push_back(d);
            end
        endfunction

        function void check_digit(t_digit got);
            t_digit want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected digit: char %0d count %0d last %0d",
                             got.digit_char, got.digit_count, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.digit_char !== want.digit_char || got.digit_count !== want.digit_count
                    || got.last !== want.last) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"digit mismatch: expected char %0d count %0d last %0d, ",
                              "got char %0d count %0d last %0d"},
                             want.digit_char, want.digit_count, want.last,
                             got.digit_char, got.digit_count, got.last);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [VALUE_W-1:0] i_value;
    logic               empty;
    logic               pop;
    logic [CHAR_W-1:0]  o_digit_char;
    logic [CNT_W-1:0]   o_digit_count;
    logic               o_last;

    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;
    int unsigned        quiet_cycles;
    digit_scoreboard    sb;

    unsigned_to_decimal_digits_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_value       (i_value),
        .empty         (empty),
        .pop           (pop),
        .o_digit_char  (o_digit_char),
        .o_digit_count (o_digit_count),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check popped digits and end the run if traffic stops.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_digit('{o_digit_char, o_digit_count, o_last});
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_unsigned_to_decimal_digits_unit NOT OK");
            $finish;
        end
    end

    // Hold push high across back-to-back requests; drop it only while idling.
    task automatic send_value(logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (full);
        sb.note_value(value);
    endtask

    // Spread values over all digit lengths, with some zeros and raw patterns.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned     kind;
        int unsigned     ndig;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned raw;
        kind = $urandom_range(99);
        raw  = $urandom;
        if (kind < 5)
            return '0;
        if (kind < 25)
            return VALUE_W'(raw);
        ndig = $urandom_range(10, 1);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
        return VALUE_W'(lo + raw % (hi - lo + 1));
    endfunction

    task automatic drain_results();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb             = new();
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        i_value <= '0;
        pop     <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (phase == 0)
                foreach (CORNER_VALUES[k])
                    send_value(CORNER_VALUES[k]);
            repeat (RANDOM_PER_PHASE) send_value(pick_value());
            push <= 1'b0;
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_unsigned_to_decimal_digits_unit OK");
        else
            $display("tb_unsigned_to_decimal_digits_unit NOT OK");
        $finish;
    end

endmodule
